### hw/rtl/mscd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the countdown timer table.
// No dependencies; used by mscd_cell and the top level.
package mscd_pkg;

	localparam int SLOT_W    = 6;
	localparam int SLOT_RES_W = 5;
	localparam int ADDR_W    = 32;
	localparam int COUNT_W   = 32;

	// Operation codes carried by a request
	typedef enum logic [1:0] {
		OP_REGISTER = 2'd0,
		OP_ARM      = 2'd1,
		OP_TICK     = 2'd2,
		OP_DRAIN    = 2'd3
	} op_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_EXEC  = 2'd1,
		ST_DRAIN = 2'd2
	} state_t;

	typedef struct packed {
		op_t                 op;
		logic [SLOT_W-1:0]   slot;
		logic [ADDR_W-1:0]   handler_address;
		logic [COUNT_W-1:0]  delay;
	} req_t;

	typedef struct packed {
		logic                  fired;
		logic [SLOT_RES_W-1:0] slot_res;
		logic [ADDR_W-1:0]     handler_address_res;
		logic                  last;
	} res_t;

	// Broadcast control from the sequencer to every cell
	typedef struct packed {
		logic exec;   // apply the held request this cycle
		logic step;   // emit the lowest pending slot this cycle
		req_t req;
	} cmd_t;

	// Data rippling from cell to cell during a drain
	typedef struct packed {
		logic              seen;     // some lower cell is pending
		logic              rest;     // a pending cell remains after this grant
		logic [SLOT_W-1:0] idx;      // index of the granted cell
		logic [ADDR_W-1:0] handler;  // handler of the granted cell
	} chain_t;

endpackage

### hw/rtl/mscd_cell.sv
`timescale 1ns / 1ps
// One timer slot: handler, countdown, armed and drain-pending flags.
// Depends on mscd_pkg; chained by the top level in slot order.
module mscd_cell #(
	parameter int IDX = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  mscd_pkg::cmd_t   cmd,
	input  mscd_pkg::chain_t chain_in,
	output mscd_pkg::chain_t chain_out,
	output logic            grant
);

	localparam logic [mscd_pkg::SLOT_W-1:0] IDX_V = mscd_pkg::SLOT_W'(IDX);

	logic [mscd_pkg::ADDR_W-1:0]  handler_q;
	logic [mscd_pkg::COUNT_W-1:0] count_q;
	logic                         armed_q;
	logic                         pending_q;
	logic                         hit;
	logic                         expired;

	assign hit     = cmd.req.slot == IDX_V;
	assign expired = armed_q && (count_q == '0);

	// Lowest pending cell wins the output this cycle
	assign grant = pending_q && !chain_in.seen;

	always_comb begin
		chain_out.seen    = chain_in.seen | pending_q;
		chain_out.rest    = chain_in.rest | (pending_q & ~grant);
		chain_out.idx     = chain_in.idx | (grant ? IDX_V : '0);
		chain_out.handler = chain_in.handler | (grant ? handler_q : '0);
	end

	// Slot state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			handler_q <= '0;
			count_q   <= '0;
			armed_q   <= 1'b0;
			pending_q <= 1'b0;
		end else if (cmd.exec) begin
			unique case (cmd.req.op)
				mscd_pkg::OP_REGISTER: begin
					if (hit) handler_q <= cmd.req.handler_address;
				end
				mscd_pkg::OP_ARM: begin
					if (hit && handler_q != '0) begin
						count_q <= cmd.req.delay;
						armed_q <= 1'b1;
					end
				end
				mscd_pkg::OP_TICK: begin
					if (armed_q && count_q != '0) count_q <= count_q - 1'b1;
				end
				mscd_pkg::OP_DRAIN: begin
					// disarm on expiry; report only with a handler present
					if (expired) armed_q <= 1'b0;
					pending_q <= expired && (handler_q != '0);
				end
			endcase
		end else if (cmd.step && grant) begin
			pending_q <= 1'b0;
		end
	end

endmodule

### hw/rtl/multi_slot_countdown_timer_table_unit.sv
`timescale 1ns / 1ps
// Countdown timer table: sequencer, request register and a chain of slot cells.
// Depends on mscd_pkg and mscd_cell.
//
//  channel   ports                 handshake
//  request   start, busy, req      taken when start && !busy
//  result    res_valid, res        one-cycle strobe, cannot be held off
//
// Register, arm and tick capture the request, then all cells update at once.
// Drain first marks expired slots, then gives one result per cycle for each
// reported slot (a single empty result if there is none) from the priority
// ripple along the cell chain. Each result strobes in the cycle after its drain step.
// Reset clears every slot; the block is ready in the first cycle after reset.
module multi_slot_countdown_timer_table_unit #(
	parameter int SLOT_COUNT = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  mscd_pkg::req_t req,
	output logic           res_valid,
	output mscd_pkg::res_t res
);

	mscd_pkg::state_t state_q;
	mscd_pkg::state_t state_d;
	mscd_pkg::req_t   req_q;
	mscd_pkg::cmd_t   cmd;
	mscd_pkg::chain_t chain [SLOT_COUNT+1];
	logic [SLOT_COUNT-1:0] grant_vec;
	logic             res_valid_q;
	mscd_pkg::res_t   res_q;
	logic             accept;

	assign accept = start && !busy;

	// Request capture
	always_ff @(posedge clk) begin
		if (accept) req_q <= req;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mscd_pkg::ST_IDLE:  if (start) state_d = mscd_pkg::ST_EXEC;
			mscd_pkg::ST_EXEC:
				state_d = (req_q.op == mscd_pkg::OP_DRAIN) ? mscd_pkg::ST_DRAIN
				                                          : mscd_pkg::ST_IDLE;
			mscd_pkg::ST_DRAIN:
				if (!chain[SLOT_COUNT].rest) state_d = mscd_pkg::ST_IDLE;
			default:            state_d = mscd_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		busy     = state_q != mscd_pkg::ST_IDLE;
		cmd.exec = state_q == mscd_pkg::ST_EXEC;
		cmd.step = state_q == mscd_pkg::ST_DRAIN;
		cmd.req  = req_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= mscd_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	// Cell chain
	assign chain[0] = '0;

	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		mscd_cell #(.IDX(i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.chain_in (chain[i]),
			.chain_out(chain[i+1]),
			.grant    (grant_vec[i])
		);
	end

	// Result register; an empty drain yields fired=0, last=1 with zero fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid_q <= 1'b0;
		else         res_valid_q <= cmd.step;
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			res_q.fired               <= chain[SLOT_COUNT].seen;
			res_q.slot_res            <= chain[SLOT_COUNT].idx[mscd_pkg::SLOT_RES_W-1:0];
			res_q.handler_address_res <= chain[SLOT_COUNT].handler;
			res_q.last                <= !chain[SLOT_COUNT].rest;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Checks
	a_one_grant: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(grant_vec)) else $error("more than one cell granted");

	a_res_from_drain: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> $past(state_q) == mscd_pkg::ST_DRAIN)
		else $error("result outside a drain");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.last |-> state_q == mscd_pkg::ST_IDLE)
		else $error("drain continues after last result");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == mscd_pkg::ST_EXEC)
		else $error("accepted request not executed");

	a_fired_handler: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.fired |-> res.handler_address_res != '0)
		else $error("fired result with zero handler");

endmodule
